// ===== src/synchsafe_tag_stream_deframer_defines.svh =====
// Assertion macros for the synchsafe tag stream deframer checker.
// Used by files that assert; expects clk and arst_n in scope.
`ifndef SYNCHSAFE_TAG_STREAM_DEFRAMER_DEFINES_SVH
`define SYNCHSAFE_TAG_STREAM_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SSTD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SSTD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sstd_pkg.sv =====
// Shared types and constants for the synchsafe tag stream deframer.
// No dependencies.
package sstd_pkg;

	localparam int OFFSET_BITS_DEF = 48;
	localparam int TAG_POS_W       = 48;
	localparam int LEN_W           = 28;
	localparam int NAME_W          = 32;
	localparam int BYTE_W          = 8;
	localparam int MAGIC_W         = 32;
	localparam int SAFE_W          = 7;
	localparam int FC_W            = 3;
	localparam int Q_DEPTH         = 2;

	// field counter milestones
	localparam logic [FC_W-1:0] FC_LEN_LAST  = FC_W'(3);
	localparam logic [FC_W-1:0] FC_NAME_END  = FC_W'(4);
	localparam logic [FC_W-1:0] FC_HDR_LAST  = FC_W'(7);

	typedef enum logic [1:0] {
		KIND_TAG_FOUND = 2'd0,
		KIND_ITEM_BYTE = 2'd1,
		KIND_MALFORMED = 2'd2,
		KIND_TAG_END   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_HDR  = 2'd2,
		PH_DATA = 2'd3
	} phase_t;

	typedef struct packed {
		kind_t                kind;
		logic [NAME_W-1:0]    item_name;
		logic [BYTE_W-1:0]    item_byte;
		logic [LEN_W-1:0]     byte_index;
		logic [TAG_POS_W-1:0] tag_position;
		logic [LEN_W-1:0]     tag_length;
		logic                 last_in_item;
		logic                 last_in_tag;
	} result_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} in_item_t;

endpackage

// ===== src/synchsafe_tag_stream_deframer.sv =====
// Synchsafe tag stream deframer, top level.
// Uses sstd_pkg, sstd_in_stage, sstd_core, sstd_out_queue.
//
// Input channel: one stream byte per transfer (in_valid, in_stall, data_byte).
// Output channel: at most one result per byte (out_valid, out_stall, fields).
// cfg_we with cfg_wdata loads the magic word; write only while idle.
// Throughput: one byte per cycle unless the result queue is full, limited by
// the single parser state update. A result passes through the input register
// and the result queue before it reaches the outputs; bytes that give no
// result simply advance the parser.
// The input register feeds the parser; a two-entry queue holds results, so
// input transfers continue while a result waits. When the queue is full and
// the input register is occupied, in_stall rises.
// Reset clears the parser to hunting, the stream offset and magic word to
// zero, and empties the input register and result queue. No clearing pass.
module synchsafe_tag_stream_deframer #(
	parameter int OFFSET_BITS = sstd_pkg::OFFSET_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sstd_pkg::MAGIC_W-1:0]   cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [sstd_pkg::BYTE_W-1:0]    data_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     kind,
	output logic [sstd_pkg::NAME_W-1:0]    item_name,
	output logic [sstd_pkg::BYTE_W-1:0]    item_byte,
	output logic [sstd_pkg::LEN_W-1:0]     byte_index,
	output logic [sstd_pkg::TAG_POS_W-1:0] tag_position,
	output logic [sstd_pkg::LEN_W-1:0]     tag_length,
	output logic                           last_in_item,
	output logic                           last_in_tag
);
	import sstd_pkg::*;

	in_item_t item_s1;
	logic     take;
	logic     q_full;
	logic     res_valid;
	result_t  res;
	result_t  out_data;

	assign take = item_s1.valid && !q_full;

	sstd_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.data_byte (data_byte),
		.in_stall  (in_stall),
		.take      (take),
		.item_s1   (item_s1)
	);

	sstd_core #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.in_byte   (item_s1.data),
		.res_valid (res_valid),
		.res       (res)
	);

	sstd_out_queue u_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (q_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign kind         = out_data.kind;
	assign item_name    = out_data.item_name;
	assign item_byte    = out_data.item_byte;
	assign byte_index   = out_data.byte_index;
	assign tag_position = out_data.tag_position;
	assign tag_length   = out_data.tag_length;
	assign last_in_item = out_data.last_in_item;
	assign last_in_tag  = out_data.last_in_tag;

endmodule

// ===== src/sstd_in_stage.sv =====
// Input register stage of the deframer.
// Depends on sstd_pkg.
module sstd_in_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [sstd_pkg::BYTE_W-1:0] data_byte,
	output logic                      in_stall,
	input  logic                      take,
	output sstd_pkg::in_item_t        item_s1
);
	import sstd_pkg::*;

	logic load;

	assign in_stall = item_s1.valid && !take;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1.valid <= 1'b0;
			item_s1.data  <= '0;
		end else if (load) begin
			item_s1.valid <= 1'b1;
			item_s1.data  <= data_byte;
		end else if (take) begin
			item_s1.valid <= 1'b0;
		end
	end

endmodule

// ===== src/sstd_core.sv =====
// Parser state and per-byte result logic of the deframer.
// Depends on sstd_pkg.
module sstd_core #(
	parameter int OFFSET_BITS = sstd_pkg::OFFSET_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [sstd_pkg::MAGIC_W-1:0] cfg_wdata,
	input  logic                         take,
	input  logic [sstd_pkg::BYTE_W-1:0]  in_byte,
	output logic                         res_valid,
	output sstd_pkg::result_t            res
);
	import sstd_pkg::*;

	phase_t                 phase_q, phase_nx;
	logic [MAGIC_W-1:0]     magic_q;
	logic [MAGIC_W-1:0]     mw_q, mw_nx;
	logic [FC_W-1:0]        fc_q, fc_nx;
	logic [LEN_W-1:0]       la_q, la_nx;
	logic [LEN_W-1:0]       tr_q, tr_nx;
	logic [LEN_W-1:0]       ir_q, ir_nx;
	logic [NAME_W-1:0]      name_q, name_nx;
	logic [LEN_W-1:0]       idx_q, idx_nx;
	logic [OFFSET_BITS-1:0] off_q;
	logic [OFFSET_BITS-1:0] start_q, start_nx;

	logic [MAGIC_W-1:0]     mw_sh;
	logic [LEN_W-1:0]       la_sh;
	logic [LEN_W-1:0]       tr_dec;
	logic [LEN_W-1:0]       ir_dec;
	logic [NAME_W-1:0]      name_hdr;
	logic [LEN_W-1:0]       ir_hdr;
	logic [SAFE_W-1:0]      b7;
	logic                   hunt_hit;
	logic                   last_item;
	logic                   tag_closes;
	logic [OFFSET_BITS+TAG_POS_W-1:0] start_ext;

	assign b7       = in_byte[SAFE_W-1:0];
	assign mw_sh    = {mw_q[MAGIC_W-BYTE_W-1:0], in_byte};
	assign la_sh    = {la_q[LEN_W-SAFE_W-1:0], b7};
	assign tr_dec   = tr_q - LEN_W'(1);
	assign ir_dec   = ir_q - LEN_W'(1);
	assign hunt_hit = (fc_q >= FC_LEN_LAST) && (mw_sh == magic_q);
	assign last_item  = (ir_q <= LEN_W'(1));
	assign tag_closes = (tr_q <= LEN_W'(1));
	assign start_ext = {{TAG_POS_W{1'b0}}, start_q};

	always_comb begin
		name_hdr = name_q;
		ir_hdr   = ir_q;
		if (fc_q < FC_NAME_END)
			name_hdr = {name_q[NAME_W-BYTE_W-1:0], in_byte};
		else if (fc_q == FC_NAME_END)
			ir_hdr = {{(LEN_W-SAFE_W){1'b0}}, b7};
		else
			ir_hdr = {ir_q[LEN_W-SAFE_W-1:0], b7};
	end

	// next state
	always_comb begin
		phase_nx = phase_q;
		mw_nx    = mw_q;
		fc_nx    = fc_q;
		la_nx    = la_q;
		tr_nx    = tr_q;
		ir_nx    = ir_q;
		name_nx  = name_q;
		idx_nx   = idx_q;
		start_nx = start_q;
		unique case (phase_q)
			PH_HUNT: begin
				mw_nx = mw_sh;
				if (fc_q < FC_NAME_END)
					fc_nx = fc_q + FC_W'(1);
				if (hunt_hit) begin
					start_nx = off_q - OFFSET_BITS'(3);
					phase_nx = PH_LEN;
					fc_nx    = '0;
					la_nx    = '0;
				end
			end
			PH_LEN: begin
				la_nx = la_sh;
				fc_nx = fc_q + FC_W'(1);
				if (fc_q == FC_LEN_LAST) begin
					tr_nx = la_sh;
					fc_nx = '0;
					mw_nx = '0;
					phase_nx = (la_sh == '0) ? PH_HUNT : PH_HDR;
				end
			end
			PH_HDR: begin
				tr_nx   = tr_dec;
				name_nx = name_hdr;
				ir_nx   = ir_hdr;
				if (fc_q != FC_HDR_LAST) begin
					fc_nx = fc_q + FC_W'(1);
					if (tr_dec == '0) begin
						phase_nx = PH_HUNT;
						mw_nx    = '0;
						fc_nx    = '0;
					end
				end else begin
					fc_nx = '0;
					if (ir_hdr > tr_dec) begin
						phase_nx = PH_HUNT;
						mw_nx    = '0;
					end else if (ir_hdr == '0) begin
						if (tr_dec == '0) begin
							phase_nx = PH_HUNT;
							mw_nx    = '0;
						end
					end else begin
						phase_nx = PH_DATA;
						idx_nx   = '0;
					end
				end
			end
			PH_DATA: begin
				tr_nx  = tr_dec;
				ir_nx  = ir_dec;
				idx_nx = idx_q + LEN_W'(1);
				if (tag_closes) begin
					phase_nx = PH_HUNT;
					mw_nx    = '0;
					fc_nx    = '0;
				end else if (last_item) begin
					phase_nx = PH_HDR;
					fc_nx    = '0;
				end
			end
			default: phase_nx = PH_HUNT;
		endcase
	end

	// result for the byte in flight
	always_comb begin
		res_valid        = 1'b0;
		res.kind         = KIND_TAG_FOUND;
		res.item_name    = '0;
		res.item_byte    = '0;
		res.byte_index   = '0;
		res.tag_position = start_ext[TAG_POS_W-1:0];
		res.tag_length   = la_q;
		res.last_in_item = 1'b0;
		res.last_in_tag  = 1'b0;
		unique case (phase_q)
			PH_HUNT: res_valid = 1'b0;
			PH_LEN: begin
				res.tag_length = la_sh;
				if (fc_q == FC_LEN_LAST) begin
					res_valid       = take;
					res.last_in_tag = (la_sh == '0);
				end
			end
			PH_HDR: begin
				res.item_name = name_hdr;
				if (fc_q != FC_HDR_LAST) begin
					if (tr_dec == '0) begin
						res_valid       = take;
						res.kind        = KIND_MALFORMED;
						res.last_in_tag = 1'b1;
					end
				end else if (ir_hdr > tr_dec) begin
					res_valid = take;
					res.kind  = KIND_MALFORMED;
				end else if (ir_hdr == '0 && tr_dec == '0) begin
					res_valid       = take;
					res.kind        = KIND_TAG_END;
					res.last_in_tag = 1'b1;
				end
			end
			PH_DATA: begin
				res_valid        = take;
				res.kind         = KIND_ITEM_BYTE;
				res.item_name    = name_q;
				res.item_byte    = in_byte;
				res.byte_index   = idx_q;
				res.last_in_item = last_item;
				res.last_in_tag  = tag_closes;
			end
			default: res_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= '0;
		end else if (cfg_we) begin
			magic_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			mw_q    <= '0;
			fc_q    <= '0;
			la_q    <= '0;
			tr_q    <= '0;
			ir_q    <= '0;
			name_q  <= '0;
			idx_q   <= '0;
			off_q   <= '0;
			start_q <= '0;
		end else if (take) begin
			phase_q <= phase_nx;
			mw_q    <= mw_nx;
			fc_q    <= fc_nx;
			la_q    <= la_nx;
			tr_q    <= tr_nx;
			ir_q    <= ir_nx;
			name_q  <= name_nx;
			idx_q   <= idx_nx;
			off_q   <= off_q + OFFSET_BITS'(1);
			start_q <= start_nx;
		end
	end

endmodule

// ===== src/sstd_out_queue.sv =====
// Two-entry result queue between the parser and the output channel.
// Depends on sstd_pkg.
module sstd_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sstd_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output sstd_pkg::result_t out_data
);
	import sstd_pkg::*;

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	result_t          mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign full      = (cnt_q == CNT_W'(Q_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

// ===== src/sstd_checker.sv =====
// Port-level checker for the deframer, bound to the top level.
// Uses sstd_pkg and synchsafe_tag_stream_deframer_defines.svh.
`include "synchsafe_tag_stream_deframer_defines.svh"

module sstd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [1:0]                     kind,
	input logic [sstd_pkg::NAME_W-1:0]    item_name,
	input logic [sstd_pkg::BYTE_W-1:0]    item_byte,
	input logic [sstd_pkg::LEN_W-1:0]     byte_index,
	input logic [sstd_pkg::LEN_W-1:0]     tag_length,
	input logic                           last_in_item,
	input logic                           last_in_tag
);
	import sstd_pkg::*;

	`SSTD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(item_name), "stalled result changed")
	`SSTD_ASSERT_SAME(a_non_data_zero, out_valid && kind != KIND_ITEM_BYTE, item_byte == '0 && byte_index == '0 && !last_in_item, "non-data result carries data fields")
	`SSTD_ASSERT_SAME(a_found_name, out_valid && kind == KIND_TAG_FOUND, item_name == '0, "tag found with nonzero name")
	`SSTD_ASSERT_SAME(a_found_empty, out_valid && kind == KIND_TAG_FOUND, last_in_tag == (tag_length == '0), "tag found end flag mismatch")
	`SSTD_ASSERT_SAME(a_end_closes, out_valid && kind == KIND_TAG_END, last_in_tag, "tag end without last_in_tag")

endmodule

bind synchsafe_tag_stream_deframer sstd_checker u_sstd_checker (.*);

// ===== tb/sstd_tb_model_pkg.sv =====
// Bit-level predictor of the synchsafe tag stream deframer, with a queue of
// pending results and field-by-field checking. Depends on sstd_pkg.
`timescale 1ns / 1ps

package sstd_tb_model_pkg;
	import sstd_pkg::*;

	class tag_stream_model;
		logic [MAGIC_W-1:0]   magic;
		phase_t               phase;
		logic [31:0]          window;
		logic [FC_W-1:0]      fcount;
		logic [LEN_W-1:0]     tag_len;
		logic [LEN_W-1:0]     tag_left;
		logic [LEN_W-1:0]     item_left;
		logic [NAME_W-1:0]    name;
		logic [LEN_W-1:0]     item_idx;
		logic [TAG_POS_W-1:0] offset;
		logic [TAG_POS_W-1:0] tag_start;
		result_t              pending_results[$];
		int                   errors;
		int                   kind_seen[4];

		function new();
			magic     = '0;
			tag_len   = '0;
			tag_left  = '0;
			item_left = '0;
			name      = '0;
			item_idx  = '0;
			offset    = '0;
			tag_start = '0;
			errors    = 0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
			hunt();
		endfunction

		function void hunt();
			phase  = PH_HUNT;
			window = '0;
			fcount = '0;
		endfunction

		// one accepted stream byte; queues the result it causes, if any
		function void note_byte(logic [BYTE_W-1:0] b);
			logic [TAG_POS_W-1:0] pos;
			result_t r;
			bit hit;
			pos    = offset;
			offset = offset + 1'b1;
			hit    = 1'b0;
			r      = '0;
			case (phase)
				PH_HUNT: begin
					window = {window[23:0], b};
					if (fcount < 3'd4) fcount = fcount + 3'd1;
					if (fcount >= 3'd4 && window == magic) begin
						tag_start = pos - 3;
						phase     = PH_LEN;
						fcount    = '0;
						tag_len   = '0;
					end
				end
				PH_LEN: begin
					tag_len = {tag_len[20:0], b[6:0]};
					fcount  = fcount + 3'd1;
					if (fcount == 3'd4) begin
						tag_left = tag_len;
						hit      = 1'b1;
						r.kind   = KIND_TAG_FOUND;
						if (tag_len == 0) begin
							r.last_in_tag = 1'b1;
							hunt();
						end else begin
							phase  = PH_HDR;
							fcount = '0;
						end
					end
				end
				PH_HDR: begin
					tag_left = tag_left - 1'b1;
					if (fcount < 3'd4) name = {name[23:0], b};
					else if (fcount == 3'd4) item_left = {21'd0, b[6:0]};
					else item_left = {item_left[20:0], b[6:0]};
					if (fcount < 3'd7) begin
						fcount = fcount + 3'd1;
						if (tag_left == 0) begin
							// body ran out inside an item header
							hit = 1'b1;
							r.kind = KIND_MALFORMED;
							r.item_name = name;
							r.last_in_tag = 1'b1;
							hunt();
						end
					end else if (item_left > tag_left) begin
						hit = 1'b1;
						r.kind = KIND_MALFORMED;
						r.item_name = name;
						hunt();
					end else begin
						fcount = '0;
						if (item_left == 0) begin
							if (tag_left == 0) begin
								hit = 1'b1;
								r.kind = KIND_TAG_END;
								r.item_name = name;
								r.last_in_tag = 1'b1;
								hunt();
							end
						end else begin
							phase    = PH_DATA;
							item_idx = '0;
						end
					end
				end
				default: begin
					hit            = 1'b1;
					r.kind         = KIND_ITEM_BYTE;
					r.item_name    = name;
					r.item_byte    = b;
					r.byte_index   = item_idx;
					r.last_in_item = (item_left <= 1);
					r.last_in_tag  = (tag_left <= 1);
					tag_left  = tag_left - 1'b1;
					item_left = item_left - 1'b1;
					item_idx  = item_idx + 1'b1;
					if (r.last_in_tag) hunt();
					else if (r.last_in_item) begin
						phase  = PH_HDR;
						fcount = '0;
					end
				end
			endcase
			if (hit) begin
				r.tag_position = tag_start;
				r.tag_length   = tag_len;
				pending_results.push_back(r);
			end
		endfunction

		function void cmp(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: kind %0d", got.kind);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			kind_seen[want.kind]++;
			cmp("kind", want.kind, got.kind);
			cmp("item_name", want.item_name, got.item_name);
			cmp("item_byte", want.item_byte, got.item_byte);
			cmp("byte_index", want.byte_index, got.byte_index);
			cmp("tag_position", want.tag_position, got.tag_position);
			cmp("tag_length", want.tag_length, got.tag_length);
			cmp("last_in_item", want.last_in_item, got.last_in_item);
			cmp("last_in_tag", want.last_in_tag, got.last_in_tag);
		endfunction
	endclass

endpackage

// ===== tb/tb_synchsafe_tag_stream_deframer.sv =====
// Top-level testbench for synchsafe_tag_stream_deframer: directed and random
// tag streams under several magic words. Depends on sstd_pkg, sstd_tb_model_pkg.
`timescale 1ns / 1ps

module tb_synchsafe_tag_stream_deframer;
	import sstd_pkg::*;
	import sstd_tb_model_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_BYTES = 425;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [MAGIC_W-1:0]   cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [BYTE_W-1:0]    data_byte = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           kind;
	logic [NAME_W-1:0]    item_name;
	logic [BYTE_W-1:0]    item_byte;
	logic [LEN_W-1:0]     byte_index;
	logic [TAG_POS_W-1:0] tag_position;
	logic [LEN_W-1:0]     tag_length;
	logic                 last_in_item;
	logic                 last_in_tag;

	tag_stream_model      model;
	logic [BYTE_W-1:0]    stream_q[$];
	logic [MAGIC_W-1:0]   magic_now = '0;
	bit                   calm = 1'b0;
	int                   idle_cycles = 0;
	int                   bytes_in = 0;

	synchsafe_tag_stream_deframer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.item_name   (item_name),
		.item_byte   (item_byte),
		.byte_index  (byte_index),
		.tag_position(tag_position),
		.tag_length  (tag_length),
		.last_in_item(last_in_item),
		.last_in_tag (last_in_tag)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 35);
	end

	always @(posedge clk) begin : monitor
		result_t got;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				model.note_byte(data_byte);
				bytes_in++;
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				got.kind         = kind_t'(kind);
				got.item_name    = item_name;
				got.item_byte    = item_byte;
				got.byte_index   = byte_index;
				got.tag_position = tag_position;
				got.tag_length   = tag_length;
				got.last_in_item = last_in_item;
				got.last_in_tag  = last_in_tag;
				model.check_result(got);
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic write_magic(input logic [MAGIC_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		model.magic = value;
		magic_now   = value;
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while (!calm && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_stream();
		while (stream_q.size() != 0) send_byte(stream_q.pop_front());
		in_valid <= 1'b0;
	endtask

	// drain pending results, then cover bytes still in the pipe
	task automatic settle();
		while (model.pending_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// 28-bit synchsafe value, top bit of each byte set at random
	function automatic logic [31:0] safe_word(input logic [27:0] v);
		logic [31:0] w;
		for (int i = 0; i < 4; i++)
			w[8*i +: 8] = {1'($urandom_range(0, 3) == 0), v[7*i +: 7]};
		return w;
	endfunction

	function automatic int item_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 18) return 0;
		if (r < 90) return $urandom_range(1, 6);
		return $urandom_range(7, 40);
	endfunction

	// noise, then a tag: mostly well formed, some empty, cut short, padded or overrun
	task automatic queue_tag();
		logic [BYTE_W-1:0] body[$];
		logic [31:0]       word;
		logic [27:0]       body_len;
		int                flavor, n_items, len, declared, k;
		flavor = $urandom_range(0, 99);
		repeat ($urandom_range(0, 5)) stream_q.push_back(8'($urandom_range(0, 255)));
		for (int i = 3; i >= 0; i--) stream_q.push_back(magic_now[8*i +: 8]);
		if (flavor < 8) begin
			word = safe_word('0);
			for (int i = 3; i >= 0; i--) stream_q.push_back(word[8*i +: 8]);
			return;
		end
		n_items = $urandom_range(1, 4);
		for (int n = 0; n < n_items; n++) begin
			word = $urandom;
			for (int i = 3; i >= 0; i--) body.push_back(word[8*i +: 8]);
			len = item_len();
			declared = len;
			if (flavor >= 90 && n == n_items - 1) declared = len + $urandom_range(1, 40);
			word = safe_word(28'(declared));
			for (int i = 3; i >= 0; i--) body.push_back(word[8*i +: 8]);
			repeat (len) body.push_back(8'($urandom_range(0, 255)));
		end
		body_len = 28'(body.size());
		if (flavor >= 78 && flavor < 90) begin
			k = $urandom_range(1, 8);
			if (flavor < 84 && body_len > k) body_len = body_len - 28'(k);
			else body_len = body_len + 28'(k);
		end
		word = safe_word(body_len);
		for (int i = 3; i >= 0; i--) stream_q.push_back(word[8*i +: 8]);
		foreach (body[i]) stream_q.push_back(body[i]);
	endtask

	initial begin
		logic [MAGIC_W-1:0] phase_magic[4];
		int queued;
		model = new();
		phase_magic[0] = $urandom;
		phase_magic[1] = 32'h0000_0000;
		phase_magic[2] = 32'hFFFF_FFFF;
		phase_magic[3] = {8'($urandom_range(0, 255)), 24'h544147};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset magic of zero: four zero bytes, then an empty tag with top bits set
		repeat (4) stream_q.push_back(8'h00);
		repeat (4) stream_q.push_back(8'h80);
		send_stream();
		settle();

		// all-ones magic, largest body length, item longer than the body
		write_magic(32'hFFFF_FFFF);
		repeat (8) stream_q.push_back(8'hFF);
		stream_q.push_back(8'h00);
		stream_q.push_back(8'hFF);
		stream_q.push_back(8'h00);
		stream_q.push_back(8'hFF);
		repeat (4) stream_q.push_back(8'hFF);
		send_stream();
		settle();

		queued = 0;
		for (int ph = 0; ph < 4; ph++) begin
			write_magic(phase_magic[ph]);
			calm = (ph == 1);
			while (queued < PHASE_BYTES * (ph + 1)) begin
				queue_tag();
				queued = queued + stream_q.size();
				send_stream();
			end
			settle();
		end
		calm = 1'b0;

		model.errors = model.errors + model.pending_results.size();
		$display("Streamed %0d bytes under four magic words, with and without idling.",
			bytes_in);
		$display("Results: %0d tags found, %0d data bytes, %0d malformed, %0d tag ends.",
			model.kind_seen[KIND_TAG_FOUND], model.kind_seen[KIND_ITEM_BYTE],
			model.kind_seen[KIND_MALFORMED], model.kind_seen[KIND_TAG_END]);
		if (model.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== synchsafe_tag_stream_deframer.f =====
+incdir+src
src/sstd_pkg.sv
src/sstd_in_stage.sv
src/sstd_core.sv
src/sstd_out_queue.sv
src/synchsafe_tag_stream_deframer.sv
src/sstd_checker.sv
tb/sstd_tb_model_pkg.sv
tb/tb_synchsafe_tag_stream_deframer.sv
